FILE: hdl/svalu_pkg.sv
// Package for the 16-bit stack machine ALU: widths, opcodes, beat structs.
// No dependencies.
package svalu_pkg;
   localparam int DataWidth = 16;
   localparam int CellCount = DataWidth;

   typedef enum logic [4:0] {
      OP_SHIFT = 5'd0, OP_NOT = 5'd1, OP_ABS = 5'd2, OP_NEG = 5'd3,
      OP_ADD = 5'd4, OP_SUB = 5'd5, OP_MUL = 5'd6, OP_DIV = 5'd7,
      OP_MOD = 5'd8, OP_EQ = 5'd9, OP_NE = 5'd10, OP_LT = 5'd11,
      OP_LE = 5'd12, OP_GT = 5'd13, OP_GE = 5'd14, OP_AND = 5'd15,
      OP_OR = 5'd16, OP_XOR = 5'd17, OP_MIN = 5'd18, OP_MAX = 5'd19
   } op_type;

   typedef struct packed {
      logic [4:0]           op;
      logic [DataWidth-1:0] lhs;
      logic [DataWidth-1:0] rhs;
      logic signed [7:0]    shift_count;
   } req_type;

   typedef struct packed {
      logic [DataWidth-1:0] result;
      logic                 is_truth;
      logic                 divide_fault;
   } rsp_type;

   // Work carried down the divider chain.
   typedef struct packed {
      logic                 valid;
      logic                 is_div;
      logic                 is_mod;
      logic [DataWidth-1:0] rem;
      logic [DataWidth-1:0] quo;   // dividend bits shift out, quotient bits in
      logic [DataWidth-1:0] dvs;
      rsp_type              rsp;   // result for non-divide ops
   } cell_type;
endpackage

FILE: hdl/svalu_cell.sv
// One restoring-division step cell of the pipelined divider chain.
// Depends on svalu_pkg.
module svalu_cell import svalu_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     advance,
   input  cell_type cell_in,
   output cell_type cell_out
);
   cell_type             cell_ff, cell_in_w;
   logic [DataWidth:0]   trial;
   logic [DataWidth:0]   diff;

   always_comb begin
      cell_in_w = cell_in;
      trial = {cell_in.rem, cell_in.quo[DataWidth-1]};
      diff  = trial - {1'b0, cell_in.dvs};
      cell_in_w.quo = {cell_in.quo[DataWidth-2:0], ~diff[DataWidth]};
      if (diff[DataWidth]) begin
         cell_in_w.rem = trial[DataWidth-1:0];
      end else begin
         cell_in_w.rem = diff[DataWidth-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cell_ff.valid <= 1'b0;
      end else if (advance) begin
         cell_ff <= cell_in_w;
      end
   end

   assign cell_out = cell_ff;
endmodule

FILE: hdl/svalu_front.sv
// Input stage: decodes the opcode, computes all non-divide operations and
// primes the divider chain. Depends on svalu_pkg.
module svalu_front import svalu_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     advance,
   input  logic     req_valid,
   input  req_type  req_data,
   output cell_type cell_out
);
   cell_type                 cell_ff, cell_in;
   logic [DataWidth-1:0]     a, b, r;
   logic [2*DataWidth-1:0]   prod;
   logic [7:0]               mag;
   logic                     truth, zero;

   always_comb begin
      a = req_data.lhs;
      b = req_data.rhs;
      prod = a * b;
      mag = req_data.shift_count[7] ? 8'(-req_data.shift_count) : req_data.shift_count;
      zero = (b == '0);
      truth = 1'b0;
      r = '0;
      case (req_data.op)
         OP_SHIFT: begin
            if (mag >= 8'(DataWidth)) r = '0;
            else if (req_data.shift_count[7]) r = a >> mag;
            else r = a << mag;
         end
         OP_NOT: r = ~b;
         OP_ABS: r = b;
         OP_NEG: r = -b;
         OP_ADD: r = a + b;
         OP_SUB: r = a - b;
         OP_MUL: r = prod[DataWidth-1:0];
         OP_EQ: begin r = DataWidth'(a == b); truth = 1'b1; end
         OP_NE: begin r = DataWidth'(a != b); truth = 1'b1; end
         OP_LT: begin r = DataWidth'(a < b);  truth = 1'b1; end
         OP_LE: begin r = DataWidth'(a <= b); truth = 1'b1; end
         OP_GT: begin r = DataWidth'(a > b);  truth = 1'b1; end
         OP_GE: begin r = DataWidth'(a >= b); truth = 1'b1; end
         OP_AND: r = a & b;
         OP_OR:  r = a | b;
         OP_XOR: r = a ^ b;
         OP_MIN: r = (a < b) ? a : b;
         OP_MAX: r = (a > b) ? a : b;
         default: r = '0;
      endcase
      cell_in.valid  = req_valid;
      cell_in.is_div = (req_data.op == OP_DIV) && !zero;
      cell_in.is_mod = (req_data.op == OP_MOD) && !zero;
      cell_in.rem    = '0;
      cell_in.quo    = a;
      cell_in.dvs    = b;
      cell_in.rsp.result = r;
      cell_in.rsp.is_truth = truth;
      cell_in.rsp.divide_fault = zero &&
         ((req_data.op == OP_DIV) || (req_data.op == OP_MOD));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cell_ff.valid <= 1'b0;
      end else if (advance) begin
         cell_ff <= cell_in;
      end
   end

   assign cell_out = cell_ff;
endmodule

FILE: hdl/stack_vm_uint16_alu.sv
// Top level of the 16-bit stack machine ALU: front stage, divider cell chain.
// Depends on svalu_pkg, svalu_front, svalu_cell.
//
//   channel | direction | beat     | handshake
//   req     | in        | req_type | req_valid / req_stall
//   rsp     | out       | rsp_type | rsp_valid / rsp_stall
//
// One beat per cycle sustained while rsp_stall is low; a beat passes the front
// stage, then one restoring-division step per cell; every op rides the chain.
// The whole chain advances together: it holds while the last beat waits.
// Reset clears only valid bits. req_stall follows rsp_stall when the output
// beat is occupied; an empty slot anywhere does not collapse.
module stack_vm_uint16_alu import svalu_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);
   cell_type chain [CellCount+1];
   logic     advance;
   cell_type last;

   // Stall the whole chain only when the output beat is held.
   assign advance   = !(last.valid && rsp_stall);
   assign req_stall = !advance;

   svalu_front u_front (
      .clock, .reset, .advance, .req_valid, .req_data,
      .cell_out(chain[0])
   );

   for (genvar i = 0; i < CellCount; i++) begin : g_cell
      svalu_cell u_cell (
         .clock, .reset, .advance,
         .cell_in(chain[i]), .cell_out(chain[i+1])
      );
   end

   assign last      = chain[CellCount];
   assign rsp_valid = last.valid;

   always_comb begin
      rsp_data = last.rsp;
      if (last.is_div) rsp_data.result = last.quo;
      else if (last.is_mod) rsp_data.result = last.rem;
   end
endmodule
